// ----- src/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned COUNT_W  = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PEND_W   = 2;

    localparam logic [CP_W-1:0]   MAX_SCALAR     = 21'h10FFFF;
    localparam logic [CP_W-1:0]   SUPPLEMENTARY  = 21'h010000;
    localparam logic [UNIT_W-1:0] HIGH_SURROGATE = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURROGATE  = 16'hDC00;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_LEAD   = 2'd1,
        STATUS_MISSING    = 2'd2,
        STATUS_OUT_RANGE  = 2'd3
    } status_t;

    typedef enum logic [COUNT_W-1:0] {
        UNITS_NONE = 2'd0,
        UNITS_ONE  = 2'd1,
        UNITS_TWO  = 2'd2
    } unit_count_t;

    typedef struct packed {
        logic [CP_W-1:0]     code_point;
        logic [UNIT_W-1:0]   first;
        logic [UNIT_W-1:0]   second;
        unit_count_t         count;
        status_t             status;
    } result_t;

endpackage

`default_nettype wire

// ----- src/utf8_to_utf16_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// Streaming UTF-8 decoder that yields code points and their UTF-16 form.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_byte) takes one UTF-8 byte per
// word. The output channel (out_valid, out_ready and the result ports) gives
// one word for every completed character and one for every malformed byte.
// A lead byte or an inner continuation byte gives no output word.
// Each byte is first held in an input register; the decode of that byte
// against the open character writes the result register when the output
// can advance, so a result passes the input and then the result register.
// The unit accepts one byte per cycle as long as the receiver keeps up.
// When the receiver stalls, the result register holds its word and one more
// byte may wait in the input register; after that in_ready falls until the
// result is taken. Reset clears both valid flags and closes any open
// character.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [u8u16_pkg::BYTE_W-1:0]       in_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [u8u16_pkg::CP_W-1:0]              code_point,
    output logic [u8u16_pkg::UNIT_W-1:0]            utf16_first,
    output logic [u8u16_pkg::UNIT_W-1:0]            utf16_second,
    output logic [u8u16_pkg::COUNT_W-1:0]           utf16_count,
    output logic [u8u16_pkg::STATUS_W-1:0]          status
);

    import u8u16_pkg::*;

    logic                   byte_valid_reg;
    logic [BYTE_W-1:0]      byte_reg;
    logic                   out_valid_reg;
    result_t                result_reg;
    result_t                result_next;
    logic [PEND_W-1:0]      pending_reg;
    logic [PEND_W-1:0]      pending_next;
    logic [CP_W-1:0]        gathered_reg;
    logic [CP_W-1:0]        gathered_next;

    logic                   advance;
    logic                   emit;
    logic                   emit_char;
    logic                   is_cont;
    logic [CP_W-1:0]        char_value;
    logic [CP_W-1:0]        shifted;
    logic [PEND_W-1:0]      pending_dec;
    logic [CP_W-1:0]        offset_value;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !byte_valid_reg || advance;

    assign is_cont      = (byte_reg[7:6] == 2'b10);
    assign shifted      = {gathered_reg[CP_W-7:0], byte_reg[5:0]};
    assign pending_dec  = pending_reg - 2'd1;

    always_comb
    begin
        pending_next  = pending_reg;
        gathered_next = gathered_reg;
        emit          = 1'b0;
        emit_char     = 1'b0;
        char_value    = '0;
        result_next   = '{code_point: '0, first: '0, second: '0,
                          count: UNITS_NONE, status: STATUS_OK};

        if (pending_reg != '0)
        begin
            if (!is_cont)
            begin
                pending_next       = '0;
                gathered_next      = '0;
                emit               = 1'b1;
                result_next.status = STATUS_MISSING;
            end
            else
            begin
                pending_next = pending_dec;
                if (pending_dec == '0)
                begin
                    gathered_next = '0;
                    emit          = 1'b1;
                    emit_char     = 1'b1;
                    char_value    = shifted;
                end
                else
                begin
                    gathered_next = shifted;
                end
            end
        end
        else if (byte_reg[7] == 1'b0)
        begin
            emit       = 1'b1;
            emit_char  = 1'b1;
            char_value = {{(CP_W-BYTE_W){1'b0}}, byte_reg};
        end
        else if (byte_reg[7:5] == 3'b110)
        begin
            pending_next  = 2'd1;
            gathered_next = {{(CP_W-5){1'b0}}, byte_reg[4:0]};
        end
        else if (byte_reg[7:4] == 4'b1110)
        begin
            pending_next  = 2'd2;
            gathered_next = {{(CP_W-4){1'b0}}, byte_reg[3:0]};
        end
        else if (byte_reg[7:3] == 5'b11110)
        begin
            pending_next  = 2'd3;
            gathered_next = {{(CP_W-3){1'b0}}, byte_reg[2:0]};
        end
        else
        begin
            gathered_next      = '0;
            emit               = 1'b1;
            result_next.status = STATUS_BAD_LEAD;
        end

        offset_value = char_value - SUPPLEMENTARY;

        if (emit_char)
        begin
            if (char_value > MAX_SCALAR)
            begin
                result_next.status = STATUS_OUT_RANGE;
            end
            else if (char_value >= SUPPLEMENTARY)
            begin
                result_next.code_point = char_value;
                result_next.first  = HIGH_SURROGATE | {6'd0, offset_value[19:10]};
                result_next.second = LOW_SURROGATE | {6'd0, offset_value[9:0]};
                result_next.count  = UNITS_TWO;
            end
            else
            begin
                result_next.code_point = char_value;
                result_next.first      = char_value[UNIT_W-1:0];
                result_next.count      = UNITS_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pending_reg    <= '0;
            gathered_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= byte_valid_reg && emit;
                if (byte_valid_reg)
                begin
                    pending_reg  <= pending_next;
                    gathered_reg <= gathered_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
        if (advance && byte_valid_reg && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign code_point   = result_reg.code_point;
    assign utf16_first  = result_reg.first;
    assign utf16_second = result_reg.second;
    assign utf16_count  = result_reg.count;
    assign status       = result_reg.status;

endmodule

`default_nettype wire
